FILE: design/sro_pkg.sv
// ----------------------------------------------------------------------------
// sro_pkg
// Shared widths, register and wall codes, stage payload types and helper
// functions for the segment/rectangle occlusion pipeline.
// ----------------------------------------------------------------------------
package sro_pkg;

  localparam int COORD_BITS   = 16;
  localparam int SIZE_BITS    = COORD_BITS - 1;
  localparam int SUM_BITS     = COORD_BITS + 1;
  localparam int DIFF_BITS    = COORD_BITS + 2;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int FRAC_BITS    = PROD_BITS + 1;
  localparam int NUM_WALLS    = 4;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = CFG_IDX_BITS'(3);

  // wall order
  localparam int WALL_TOP    = 0;
  localparam int WALL_RIGHT  = 1;
  localparam int WALL_BOTTOM = 2;
  localparam int WALL_LEFT   = 3;

  localparam logic signed [SUM_BITS-1:0] SUM_ONE = SUM_BITS'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic        [SIZE_BITS-1:0]  width;
    logic        [SIZE_BITS-1:0]  height;
  } rect_t;

  // stage 1: differences and midpoint
  typedef struct packed {
    logic signed [DIFF_BITS-1:0] ax;
    logic signed [DIFF_BITS-1:0] ay;
    logic signed [DIFF_BITS-1:0] cx_l;
    logic signed [DIFF_BITS-1:0] cx_r;
    logic signed [DIFF_BITS-1:0] cy_t;
    logic signed [DIFF_BITS-1:0] cy_b;
    logic signed [SUM_BITS-1:0]  mid_x;
    logic signed [SUM_BITS-1:0]  mid_y;
  } prep_t;

  // stage 2: products, segment-side parameter checks and midpoint-inside flag
  typedef struct packed {
    logic signed [PROD_BITS-1:0] p_ax_cyt;
    logic signed [PROD_BITS-1:0] p_ax_cyb;
    logic signed [PROD_BITS-1:0] p_ay_cxl;
    logic signed [PROD_BITS-1:0] p_ay_cxr;
    logic signed [PROD_BITS-1:0] p_ay_w;
    logic signed [PROD_BITS-1:0] p_ax_h;
    logic        [NUM_WALLS-1:0] na_ok;
    logic        [NUM_WALLS-1:0] na_strict;
    logic                        mid_in;
  } prod_t;

  // stage 3: wall-side numerators and full denominators
  typedef struct packed {
    logic [NUM_WALLS-1:0][FRAC_BITS-1:0] nb;
    logic [NUM_WALLS-1:0][FRAC_BITS-1:0] den;
    logic [NUM_WALLS-1:0]                na_ok;
    logic [NUM_WALLS-1:0]                na_strict;
    logic                                mid_in;
  } cross_t;

  typedef struct packed {
    logic ok;
    logic strict;
  } frac_chk_t;

  // num/den in [0,1] (ok) and in (0,1) (strict); den assumed nonzero
  function automatic frac_chk_t frac_chk(input logic signed [FRAC_BITS-1:0] num,
                                         input logic signed [FRAC_BITS-1:0] den);
    frac_chk_t r;
    if (!den[FRAC_BITS-1]) begin
      r.ok     = (num >= 0) && (num <= den);
      r.strict = (num > 0) && (num < den);
    end else begin
      r.ok     = (num <= 0) && (num >= den);
      r.strict = (num < 0) && (num > den);
    end
    return r;
  endfunction

  // s/2 rounded half away from zero
  function automatic logic signed [SUM_BITS-1:0] half_round(
      input logic signed [SUM_BITS-1:0] s);
    logic signed [SUM_BITS-1:0] t;
    if (!s[0]) begin
      t = s;
    end else if (s[SUM_BITS-1]) begin
      t = s - SUM_ONE;
    end else begin
      t = s + SUM_ONE;
    end
    return t >>> 1;
  endfunction

endpackage

FILE: design/sro_prep.sv
// ----------------------------------------------------------------------------
// sro_prep
// Stage 1: direction vector, start-point offsets to the rectangle edges and
// the rounded segment midpoint.
// ----------------------------------------------------------------------------
module sro_prep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0] end_y_i,
  input  sro_pkg::rect_t                        rect_i,
  output logic                                  valid_o,
  output sro_pkg::prep_t                        prep_o
);

  logic signed [sro_pkg::DIFF_BITS-1:0] x1, y1, x2, y2;
  logic signed [sro_pkg::DIFF_BITS-1:0] left, top, right, bottom;
  sro_pkg::prep_t prep_d, prep_q;
  logic           valid_q;

  always_comb begin
    x1     = sro_pkg::DIFF_BITS'(start_x_i);
    y1     = sro_pkg::DIFF_BITS'(start_y_i);
    x2     = sro_pkg::DIFF_BITS'(end_x_i);
    y2     = sro_pkg::DIFF_BITS'(end_y_i);
    left   = sro_pkg::DIFF_BITS'(rect_i.left);
    top    = sro_pkg::DIFF_BITS'(rect_i.top);
    right  = left + sro_pkg::DIFF_BITS'($signed({1'b0, rect_i.width}));
    bottom = top + sro_pkg::DIFF_BITS'($signed({1'b0, rect_i.height}));

    prep_d.ax    = x2 - x1;
    prep_d.ay    = y2 - y1;
    prep_d.cx_l  = x1 - left;
    prep_d.cx_r  = x1 - right;
    prep_d.cy_t  = y1 - top;
    prep_d.cy_b  = y1 - bottom;
    prep_d.mid_x = sro_pkg::half_round(sro_pkg::SUM_BITS'(start_x_i)
                                       + sro_pkg::SUM_BITS'(end_x_i));
    prep_d.mid_y = sro_pkg::half_round(sro_pkg::SUM_BITS'(start_y_i)
                                       + sro_pkg::SUM_BITS'(end_y_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

FILE: design/sro_prod.sv
// ----------------------------------------------------------------------------
// sro_prod
// Stage 2: the six cross-product terms, the segment-side crossing parameter
// checks and the midpoint-inside test.
// ----------------------------------------------------------------------------
module sro_prod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sro_pkg::prep_t prep_i,
  input  sro_pkg::rect_t rect_i,
  output logic           valid_o,
  output sro_pkg::prod_t prod_o
);

  logic signed [sro_pkg::DIFF_BITS-1:0] w, h, left, top;
  logic signed [sro_pkg::DIFF_BITS-1:0] mx, my;
  logic signed [sro_pkg::FRAC_BITS-1:0] ax, ay;
  sro_pkg::frac_chk_t chk_top, chk_right, chk_bottom, chk_left;
  sro_pkg::prod_t prod_d, prod_q;
  logic           valid_q;

  always_comb begin
    w    = sro_pkg::DIFF_BITS'($signed({1'b0, rect_i.width}));
    h    = sro_pkg::DIFF_BITS'($signed({1'b0, rect_i.height}));
    left = sro_pkg::DIFF_BITS'(rect_i.left);
    top  = sro_pkg::DIFF_BITS'(rect_i.top);
    mx   = sro_pkg::DIFF_BITS'(prep_i.mid_x);
    my   = sro_pkg::DIFF_BITS'(prep_i.mid_y);
    ax   = sro_pkg::FRAC_BITS'(prep_i.ax);
    ay   = sro_pkg::FRAC_BITS'(prep_i.ay);

    prod_d.p_ax_cyt = prep_i.ax * prep_i.cy_t;
    prod_d.p_ax_cyb = prep_i.ax * prep_i.cy_b;
    prod_d.p_ay_cxl = prep_i.ay * prep_i.cx_l;
    prod_d.p_ay_cxr = prep_i.ay * prep_i.cx_r;
    prod_d.p_ay_w   = prep_i.ay * w;
    prod_d.p_ax_h   = prep_i.ax * h;

    // wall length cancels from the segment-side ratio; only its direction is left
    chk_top    = sro_pkg::frac_chk(sro_pkg::FRAC_BITS'(prep_i.cy_t), -ay);
    chk_right  = sro_pkg::frac_chk(-sro_pkg::FRAC_BITS'(prep_i.cx_r), ax);
    chk_bottom = sro_pkg::frac_chk(-sro_pkg::FRAC_BITS'(prep_i.cy_b), ay);
    chk_left   = sro_pkg::frac_chk(sro_pkg::FRAC_BITS'(prep_i.cx_l), -ax);

    prod_d.na_ok[sro_pkg::WALL_TOP]        = chk_top.ok;
    prod_d.na_ok[sro_pkg::WALL_RIGHT]      = chk_right.ok;
    prod_d.na_ok[sro_pkg::WALL_BOTTOM]     = chk_bottom.ok;
    prod_d.na_ok[sro_pkg::WALL_LEFT]       = chk_left.ok;
    prod_d.na_strict[sro_pkg::WALL_TOP]    = chk_top.strict;
    prod_d.na_strict[sro_pkg::WALL_RIGHT]  = chk_right.strict;
    prod_d.na_strict[sro_pkg::WALL_BOTTOM] = chk_bottom.strict;
    prod_d.na_strict[sro_pkg::WALL_LEFT]   = chk_left.strict;

    prod_d.mid_in = (left < mx) && (mx < left + w - sro_pkg::DIFF_BITS'(1)) &&
                    (top < my) && (my < top + h - sro_pkg::DIFF_BITS'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

FILE: design/sro_cross.sv
// ----------------------------------------------------------------------------
// sro_cross
// Stage 3: wall-side numerator and signed denominator for each wall.
// ----------------------------------------------------------------------------
module sro_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sro_pkg::prod_t  prod_i,
  output logic            valid_o,
  output sro_pkg::cross_t cross_o
);

  logic signed [sro_pkg::FRAC_BITS-1:0] ax_cyt, ax_cyb, ay_cxl, ay_cxr, ay_w, ax_h;
  sro_pkg::cross_t cross_d, cross_q;
  logic            valid_q;

  always_comb begin
    ax_cyt = sro_pkg::FRAC_BITS'(prod_i.p_ax_cyt);
    ax_cyb = sro_pkg::FRAC_BITS'(prod_i.p_ax_cyb);
    ay_cxl = sro_pkg::FRAC_BITS'(prod_i.p_ay_cxl);
    ay_cxr = sro_pkg::FRAC_BITS'(prod_i.p_ay_cxr);
    ay_w   = sro_pkg::FRAC_BITS'(prod_i.p_ay_w);
    ax_h   = sro_pkg::FRAC_BITS'(prod_i.p_ax_h);

    cross_d.nb[sro_pkg::WALL_TOP]    = ax_cyt - ay_cxl;
    cross_d.nb[sro_pkg::WALL_RIGHT]  = ax_cyt - ay_cxr;
    cross_d.nb[sro_pkg::WALL_BOTTOM] = ax_cyb - ay_cxr;
    cross_d.nb[sro_pkg::WALL_LEFT]   = ax_cyb - ay_cxl;

    cross_d.den[sro_pkg::WALL_TOP]    = -ay_w;
    cross_d.den[sro_pkg::WALL_RIGHT]  = ax_h;
    cross_d.den[sro_pkg::WALL_BOTTOM] = ay_w;
    cross_d.den[sro_pkg::WALL_LEFT]   = -ax_h;

    cross_d.na_ok     = prod_i.na_ok;
    cross_d.na_strict = prod_i.na_strict;
    cross_d.mid_in    = prod_i.mid_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cross_q <= cross_d;
    end
  end

  assign valid_o = valid_q;
  assign cross_o = cross_q;

endmodule

FILE: design/sro_decide.sv
// ----------------------------------------------------------------------------
// sro_decide
// Stage 4: wall-side range check per wall, hit rules and the output
// register.
// ----------------------------------------------------------------------------
module sro_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sro_pkg::cross_t cross_i,
  output logic            valid_o,
  output logic            blocked_o
);

  sro_pkg::frac_chk_t           chk;
  logic [sro_pkg::NUM_WALLS-1:0] hit;
  logic                          blocked_d, blocked_q;
  logic                          valid_q;

  always_comb begin
    for (int i = 0; i < sro_pkg::NUM_WALLS; i++) begin
      chk = sro_pkg::frac_chk($signed(cross_i.nb[i]), $signed(cross_i.den[i]));
      // a crossing at an endpoint counts only with the midpoint inside
      hit[i] = (cross_i.den[i] != '0) && chk.ok && cross_i.na_ok[i] &&
               (cross_i.na_strict[i] || cross_i.mid_in);
    end
    blocked_d = |hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blocked_q <= blocked_d;
    end
  end

  assign valid_o   = valid_q;
  assign blocked_o = blocked_q;

endmodule

FILE: design/segment_rectangle_occlusion_test.sv
// Pipeline: four register stages, prep, prod, cross and decide, in that order.
// Throughput: one item per cycle; the four stages advance together and
// hold in place while the output register waits for out_ready_i.
// Reset: rst_ni clears all stage valid bits and the rectangle registers
// (left, top, width, height) to zero.
// ----------------------------------------------------------------------------
// segment_rectangle_occlusion_test
// Tests one segment per item against the four walls of a configured
// axis-aligned rectangle with exact integer cross products.
// ----------------------------------------------------------------------------
module segment_rectangle_occlusion_test (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [sro_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [sro_pkg::COORD_BITS-1:0]          cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [sro_pkg::COORD_BITS-1:0]   start_x_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0]   start_y_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0]   end_x_i,
  input  logic signed [sro_pkg::COORD_BITS-1:0]   end_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    blocked_o
);

  sro_pkg::rect_t  rect_q;
  sro_pkg::prep_t  prep;
  sro_pkg::prod_t  prod;
  sro_pkg::cross_t xing;
  logic            en;
  logic            v_prep, v_prod, v_cross, v_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sro_pkg::REG_LEFT:   rect_q.left   <= cfg_data_i;
        sro_pkg::REG_TOP:    rect_q.top    <= cfg_data_i;
        sro_pkg::REG_WIDTH:  rect_q.width  <= cfg_data_i[sro_pkg::SIZE_BITS-1:0];
        sro_pkg::REG_HEIGHT: rect_q.height <= cfg_data_i[sro_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless a finished item sits unread
  assign en          = !v_out || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_out;

  sro_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .rect_i    (rect_q),
    .valid_o   (v_prep),
    .prep_o    (prep)
  );

  sro_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_prep),
    .prep_i  (prep),
    .rect_i  (rect_q),
    .valid_o (v_prod),
    .prod_o  (prod)
  );

  sro_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_prod),
    .prod_i  (prod),
    .valid_o (v_cross),
    .cross_o (xing)
  );

  sro_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v_cross),
    .cross_i   (xing),
    .valid_o   (v_out),
    .blocked_o (blocked_o)
  );

endmodule
